// ===== rtl/tft_pkg.sv =====
// Package for the thermal frequency throttle.
// Holds the action codes, register indexes, reset values and field widths.
// No dependencies.
package tft_pkg;

  localparam int NUM_FREQS_DEFAULT = 16;

  localparam int TEMP_W  = 9;
  localparam int CNT_W   = 3;
  localparam int IDX_W   = 4;
  localparam int ACT_W   = 3;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 24;
  localparam int NUM_SENSORS = 4;

  localparam logic signed [TEMP_W-1:0] NO_READING = -9'sd99;

  typedef enum logic [ACT_W-1:0] {
    ACT_KEEP     = 3'd0,
    ACT_THROTTLE = 3'd1,
    ACT_RESUME   = 3'd2,
    ACT_TWAIT    = 3'd3,
    ACT_RWAIT    = 3'd4,
    ACT_SHUTDOWN = 3'd5,
    ACT_IGNORED  = 3'd6
  } act_t;

  typedef enum logic [2:0] {
    REG_ENABLE        = 3'd0,
    REG_THROTTLE_TEMP = 3'd1,
    REG_HYSTERESIS    = 3'd2,
    REG_STEP_DOWN     = 3'd3,
    REG_STEP_UP       = 3'd4,
    REG_LAZY_TICKS    = 3'd5,
    REG_SHUTDOWN      = 3'd6,
    REG_MIN_INDEX     = 3'd7
  } reg_idx_t;

  localparam logic       RST_ENABLE        = 1'b1;
  localparam logic [6:0] RST_THROTTLE_TEMP = 7'd75;
  localparam logic [4:0] RST_HYSTERESIS    = 5'd5;
  localparam logic [2:0] RST_STEP_DOWN     = 3'd1;
  localparam logic [2:0] RST_STEP_UP       = 3'd1;
  localparam logic [2:0] RST_LAZY_TICKS    = 3'd2;
  localparam logic [7:0] RST_SHUTDOWN      = 8'd100;
  localparam logic [3:0] RST_MIN_INDEX     = 4'd8;

  localparam logic [2:0] WAIT_MAX = 3'd7;

endpackage

// ===== rtl/thermal_frequency_throttle.sv =====
// Thermal frequency throttle: hottest-sensor governor with hysteresis and a lazy wait.
// Depends on tft_pkg for action codes, register indexes and reset values.
//
// An accepted input word passes through the input register, then the decision
// logic into the result register. Throughput: one word per cycle while the result
// is not stalled; the governor state is read and written in the decision stage only.
// Reset (synchronous, active high) restores register defaults and the state.
module thermal_frequency_throttle #(
  parameter int NUM_FREQS = tft_pkg::NUM_FREQS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  // slave stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // temp_a[8:0], temp_b[17:9], temp_c[26:18], temp_d[35:27],
  // valid_count[38:36], user_top_index[42:39], zero fill above
  input  logic [tft_pkg::S_DATA_W-1:0] s_tdata,
  // master stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // action[2:0], limit_index[6:3], limit_changed[7], throttling_now[8],
  // shutdown_req[9], hottest[18:10], zero fill above
  output logic [tft_pkg::M_DATA_W-1:0] m_tdata,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tft_pkg::ADDR_W-1:0]  paddr,
  input  logic [tft_pkg::DATA_W-1:0]  pwdata,
  output logic [tft_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import tft_pkg::*;

  localparam int TopInt = (NUM_FREQS - 1 > 15) ? 15 : NUM_FREQS - 1;
  localparam logic [IDX_W-1:0] TopIdx = IDX_W'(TopInt);

  // Configuration registers
  logic       enable;
  logic [6:0] throttle_temp;
  logic [4:0] hysteresis;
  logic [2:0] step_down;
  logic [2:0] step_up;
  logic [2:0] lazy_ticks;
  logic [7:0] shutdown_temp;
  logic [3:0] min_index;

  reg_idx_t   reg_sel;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= RST_ENABLE;
      throttle_temp <= RST_THROTTLE_TEMP;
      hysteresis    <= RST_HYSTERESIS;
      step_down     <= RST_STEP_DOWN;
      step_up       <= RST_STEP_UP;
      lazy_ticks    <= RST_LAZY_TICKS;
      shutdown_temp <= RST_SHUTDOWN;
      min_index     <= RST_MIN_INDEX;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_ENABLE:        enable        <= pwdata[0];
        REG_THROTTLE_TEMP: throttle_temp <= pwdata[6:0];
        REG_HYSTERESIS:    hysteresis    <= pwdata[4:0];
        REG_STEP_DOWN:     step_down     <= pwdata[2:0];
        REG_STEP_UP:       step_up       <= pwdata[2:0];
        REG_LAZY_TICKS:    lazy_ticks    <= pwdata[2:0];
        REG_SHUTDOWN:      shutdown_temp <= pwdata[7:0];
        REG_MIN_INDEX:     min_index     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_ENABLE:        prdata = {31'd0, enable};
      REG_THROTTLE_TEMP: prdata = {25'd0, throttle_temp};
      REG_HYSTERESIS:    prdata = {27'd0, hysteresis};
      REG_STEP_DOWN:     prdata = {29'd0, step_down};
      REG_STEP_UP:       prdata = {29'd0, step_up};
      REG_LAZY_TICKS:    prdata = {29'd0, lazy_ticks};
      REG_SHUTDOWN:      prdata = {24'd0, shutdown_temp};
      REG_MIN_INDEX:     prdata = {28'd0, min_index};
      default:           prdata = '0;
    endcase
  end

  // Input register
  logic        in_valid;
  logic [42:0] in_data;
  logic        out_free;
  logic        fire;

  assign out_free = !m_tvalid || m_tready;
  assign fire     = in_valid && out_free;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata[42:0];
    end
  end

  // Governor state
  logic [IDX_W-1:0] limit_idx, limit_idx_next;
  logic [IDX_W-1:0] saved_user_idx, saved_user_idx_next;
  logic [2:0]       wait_count, wait_count_next;
  logic             throttle_flag, throttle_flag_next;

  logic signed [TEMP_W-1:0] temps [NUM_SENSORS];
  logic [CNT_W-1:0]         cnt;
  logic [IDX_W-1:0]         user_top;
  logic [IDX_W-1:0]         user_cap;
  logic [IDX_W-1:0]         mn;
  logic signed [9:0]        th_s;
  logic signed [9:0]        lo_s;
  logic signed [9:0]        sd_s;
  logic [4:0]               floor_sum;
  logic [4:0]               up_sum;
  logic signed [TEMP_W-1:0] hot;
  logic signed [9:0]        hot_s;
  act_t                     act;
  logic                     sd;

  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      temps[i] = $signed(in_data[i*TEMP_W +: TEMP_W]);
    end
  end

  assign cnt       = (in_data[38:36] > 3'd4) ? 3'd4 : in_data[38:36];
  assign user_top  = in_data[42:39];
  assign user_cap  = (user_top > TopIdx) ? TopIdx : user_top;
  assign mn        = (min_index > TopIdx) ? TopIdx : min_index;
  assign th_s      = $signed({3'b000, throttle_temp});
  assign lo_s      = th_s - $signed({5'b00000, hysteresis});
  assign sd_s      = $signed({2'b00, shutdown_temp});
  assign floor_sum = {1'b0, mn} + {2'b00, step_down};
  assign up_sum    = {1'b0, limit_idx} + {2'b00, step_up};

  // Hottest of the sensors that were read, in order.
  always_comb begin
    hot = NO_READING;
    if (enable) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        if (CNT_W'(i) < cnt && temps[i] > hot) begin
          hot = temps[i];
        end
      end
    end
  end

  assign hot_s = $signed({hot[TEMP_W-1], hot});

  always_comb begin
    act                 = ACT_IGNORED;
    sd                  = 1'b0;
    limit_idx_next      = limit_idx;
    saved_user_idx_next = saved_user_idx;
    wait_count_next     = wait_count;
    throttle_flag_next  = throttle_flag;
    if (enable && hot != NO_READING) begin
      if (hot_s > sd_s) begin
        act = ACT_SHUTDOWN;
        sd  = 1'b1;
      end else if (hot_s >= th_s) begin
        if (wait_count < lazy_ticks) begin
          act = ACT_TWAIT;
          if (wait_count < WAIT_MAX) wait_count_next = wait_count + 3'd1;
        end else begin
          act = ACT_THROTTLE;
          if (limit_idx > mn) begin
            if (!throttle_flag) saved_user_idx_next = user_cap;
            throttle_flag_next = 1'b1;
            if ({1'b0, limit_idx} >= floor_sum) begin
              limit_idx_next = limit_idx - {1'b0, step_down};
            end else begin
              limit_idx_next = mn;
            end
            wait_count_next = '0;
          end
        end
      end else if (hot_s <= lo_s && throttle_flag) begin
        if (wait_count < lazy_ticks) begin
          act = ACT_RWAIT;
          if (wait_count < WAIT_MAX) wait_count_next = wait_count + 3'd1;
        end else begin
          act = ACT_RESUME;
          if (limit_idx < saved_user_idx) begin
            if (up_sum > {1'b0, saved_user_idx}) begin
              limit_idx_next = saved_user_idx;
            end else begin
              limit_idx_next = up_sum[IDX_W-1:0];
            end
            // Reaching the saved ceiling ends the throttled episode.
            if (limit_idx_next == saved_user_idx) throttle_flag_next = 1'b0;
            wait_count_next = '0;
          end
        end
      end else begin
        act = ACT_KEEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_idx      <= TopIdx;
      saved_user_idx <= TopIdx;
      wait_count     <= '0;
      throttle_flag  <= 1'b0;
    end else if (fire) begin
      limit_idx      <= limit_idx_next;
      saved_user_idx <= saved_user_idx_next;
      wait_count     <= wait_count_next;
      throttle_flag  <= throttle_flag_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {5'd0, hot, sd, throttle_flag_next,
                  (limit_idx_next != limit_idx), limit_idx_next, act};
    end
  end

  // The limit never rises above the top index.
  assert property (@(posedge clk) disable iff (rst) limit_idx <= TopIdx)
    else $error("limit index above top index");

  // Outside a throttled episode the limit sits at the saved user ceiling.
  assert property (@(posedge clk) disable iff (rst)
    !throttle_flag |-> limit_idx == saved_user_idx)
    else $error("limit differs from saved ceiling while not throttling");

  // A stalled result freezes the governor state.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(limit_idx) && $stable(wait_count)
      && $stable(throttle_flag) && $stable(saved_user_idx))
    else $error("state moved while the result word was stalled");

  // Only a throttle or resume word may report a changed limit.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[7] |->
      m_tdata[2:0] == ACT_THROTTLE || m_tdata[2:0] == ACT_RESUME)
    else $error("limit change reported on the wrong action");

endmodule
